>>> src/hpe_pkg.sv
// Shared types, constants and state codes for the histogram clip-level unit.
package hpe_pkg;

	localparam int LEVELS = 256;
	localparam int LVL_W = $clog2(LEVELS);
	localparam int MAX_FRAME_PIXELS = 1048576;
	localparam int CNT_W = $clog2(MAX_FRAME_PIXELS + 1);
	localparam int THR_W = 21;
	localparam int SUM_W = ((CNT_W > THR_W) ? CNT_W : THR_W) + 1;

	localparam logic [LVL_W-1:0] TOP_LEVEL = LVL_W'(LEVELS - 1);
	localparam logic [LVL_W-1:0] LOW_STOP = LVL_W'(LEVELS - 2);
	localparam logic [LVL_W-1:0] HIGH_STOP = LVL_W'(1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_PIXELS);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] pixel_value;
		logic       frame_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] low_level;
		logic [7:0] high_level;
	} out_item_t;

	typedef struct packed {
		logic     valid;
		in_item_t item;
	} q_head_t;

	typedef struct packed {
		logic scanning;
	} bk_status_t;

	typedef enum logic [1:0] {
		BK_COUNT,
		BK_SCAN,
		BK_WAIT,
		BK_DONE
	} bk_state_t;

endpackage

>>> src/hpe_front.sv
// Front end: accepts pixel beats and queues them for the histogram back end.
module hpe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hpe_pkg::in_item_t in_data,
	output hpe_pkg::q_head_t  head,
	input  logic              pop
);
	import hpe_pkg::*;

	in_item_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;

	assign in_ready   = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push       = in_valid && in_ready;
	assign head.valid = (count_q != '0);
	assign head.item  = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/hpe_back.sv
// Back end: bin memory update, per-frame two-way scan and result register.
module hpe_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [hpe_pkg::THR_W-1:0] cfg_wdata,
	input  hpe_pkg::q_head_t          head,
	output logic                      pop,
	output hpe_pkg::out_item_t        out_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output hpe_pkg::bk_status_t       stat
);
	import hpe_pkg::*;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
		input logic [CNT_W-1:0] b);
		logic [SUM_W:0] t;
		t = {1'b0, s} + (SUM_W + 1)'(b);
		return t[SUM_W] ? '1 : t[SUM_W-1:0];
	endfunction

	bk_state_t          state_q, state_d;
	logic [THR_W-1:0]   thr_q;

	logic [CNT_W-1:0]   mem [LEVELS];
	logic [CNT_W-1:0]   rd_a_q, rd_b_q;
	logic [LVL_W-1:0]   rd_addr_a, rd_addr_b;
	logic [LEVELS-1:0]  vbit_q;

	// count path
	logic               v_s1, last_s1;
	logic [LVL_W-1:0]   pix_s1;
	logic               fwd_vld_q;
	logic [LVL_W-1:0]   fwd_addr_q;
	logic [CNT_W-1:0]   fwd_data_q;
	logic [CNT_W-1:0]   cnt_cur, cnt_next;

	// scan path
	logic [LVL_W-1:0]   idx_q;
	logic               sv_s1;
	logic [LVL_W-1:0]   up_lvl_s1, dn_lvl_s1;
	logic [SUM_W-1:0]   sum_up_q, sum_dn_q, sum_up_n, sum_dn_n;
	logic [CNT_W-1:0]   bin_up, bin_dn;
	logic               up_hit, dn_hit, up_done_q, dn_done_q;
	logic [LVL_W-1:0]   low_q, high_q;

	logic               out_valid_q;
	out_item_t          out_q;

	logic               scan_start, scan_issue, load_out;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_COUNT: if (v_s1 && last_s1) state_d = BK_SCAN;
			BK_SCAN:  if (idx_q == LOW_STOP) state_d = BK_WAIT;
			BK_WAIT:  state_d = BK_DONE;
			BK_DONE:  if (!out_valid_q || out_ready) state_d = BK_COUNT;
			default:  state_d = BK_COUNT;
		endcase
	end

	// outputs
	always_comb begin
		pop        = 1'b0;
		scan_start = 1'b0;
		scan_issue = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			BK_COUNT: begin
				pop        = head.valid && !(v_s1 && last_s1);
				scan_start = v_s1 && last_s1;
			end
			BK_SCAN:  scan_issue = 1'b1;
			BK_WAIT:  ;
			BK_DONE:  load_out = !out_valid_q || out_ready;
			default:  ;
		endcase
	end

	assign rd_addr_a = scan_issue ? idx_q : head.item.pixel_value;
	assign rd_addr_b = TOP_LEVEL - idx_q;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			mem[pix_s1] <= cnt_next;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	// read data misses the write landing on the same edge, so forward it
	assign cnt_cur  = (fwd_vld_q && fwd_addr_q == pix_s1) ? fwd_data_q :
		(vbit_q[pix_s1] ? rd_a_q : '0);
	assign cnt_next = (cnt_cur < CNT_MAX) ? cnt_cur + 1'b1 : cnt_cur;

	assign bin_up   = vbit_q[up_lvl_s1] ? rd_a_q : '0;
	assign bin_dn   = vbit_q[dn_lvl_s1] ? rd_b_q : '0;
	assign sum_up_n = sat_add(sum_up_q, bin_up);
	assign sum_dn_n = sat_add(sum_dn_q, bin_dn);
	assign up_hit   = (sum_up_n >= SUM_W'(thr_q));
	assign dn_hit   = (sum_dn_n >= SUM_W'(thr_q));

	always_ff @(posedge clk) begin
		pix_s1     <= head.item.pixel_value;
		last_s1    <= head.item.frame_last;
		fwd_addr_q <= pix_s1;
		fwd_data_q <= cnt_next;
		up_lvl_s1  <= idx_q;
		dn_lvl_s1  <= rd_addr_b;
		if (scan_start) begin
			sum_up_q <= '0;
			sum_dn_q <= '0;
		end else if (sv_s1) begin
			if (!up_done_q) begin
				sum_up_q <= sum_up_n;
				if (up_lvl_s1 == LOW_STOP || up_hit) begin
					low_q <= up_lvl_s1;
				end
			end
			if (!dn_done_q) begin
				sum_dn_q <= sum_dn_n;
				if (dn_lvl_s1 == HIGH_STOP || dn_hit) begin
					high_q <= dn_lvl_s1;
				end
			end
		end
		if (load_out) begin
			out_q.low_level  <= low_q;
			out_q.high_level <= high_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_COUNT;
			thr_q       <= '0;
			vbit_q      <= '0;
			v_s1        <= 1'b0;
			fwd_vld_q   <= 1'b0;
			idx_q       <= '0;
			sv_s1       <= 1'b0;
			up_done_q   <= 1'b0;
			dn_done_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			v_s1      <= pop;
			fwd_vld_q <= v_s1;
			sv_s1     <= scan_issue;
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (load_out) begin
				vbit_q <= '0;
			end else if (v_s1) begin
				vbit_q[pix_s1] <= 1'b1;
			end
			if (scan_start) begin
				idx_q <= '0;
			end else if (scan_issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (scan_start) begin
				up_done_q <= 1'b0;
				dn_done_q <= 1'b0;
			end else if (sv_s1) begin
				if (up_lvl_s1 == LOW_STOP || up_hit) up_done_q <= 1'b1;
				if (dn_lvl_s1 == HIGH_STOP || dn_hit) dn_done_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_data      = out_q;
	assign stat.scanning = (state_q != BK_COUNT);

endmodule

>>> src/histogram_percentile_extrema_unit.sv
// Frame end: BK_SCAN, BK_WAIT then BK_DONE run before out_valid is raised.
// Throughput: one pixel beat per cycle while counting; each frame end adds a
//   level scan plus the result step, during which the queue fills.
// Reset: arst_n clears control state, bin valid bits and the threshold; the
//   bin memory itself needs no clearing pass.
// Top level: pixel queue in front, histogram memory and scanner behind it.
module histogram_percentile_extrema_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  hpe_pkg::in_item_t         in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output hpe_pkg::out_item_t        out_data,
	input  logic                      cfg_we,
	input  logic [hpe_pkg::THR_W-1:0] cfg_wdata
);
	import hpe_pkg::*;

	// Front: a four-deep queue of pixel beats. in_ready drops only when full,
	// so a camera stream runs unthrottled except around the frame-end scan.
	q_head_t    head;
	logic       pop;
	bk_status_t stat;

	hpe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.head     (head),
		.pop      (pop)
	);

	// Back: read-modify-write of the bin memory, one pixel a cycle while
	// counting, with forwarding. On the last pixel it sweeps levels upward on
	// one read port and downward on the other at the same time (255 reads
	// each), then parks the two levels in the output register. A finished
	// result may wait there while the next frame is already being counted.
	hpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.pop       (pop),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat)
	);

	// no pixel enters the histogram while a frame scan is in flight
	a_no_pop_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.scanning)
		else $error("pixel popped during scan");

	// back end only pops real queue entries
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");

	// a new result only comes out of a finished scan
	a_result_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(stat.scanning))
		else $error("result without scan");

endmodule
